// File: rtl/core/aes128_block_cipher_defines.svh
// Assertion macros for the AES-128 block cipher
`ifndef AES128_BLOCK_CIPHER_DEFINES_SVH
`define AES128_BLOCK_CIPHER_DEFINES_SVH
// assert that a condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("%m failed");
// assert that a condition implies a consequence in the same cycle
`define ASSERT_NOW(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("%m failed");
`endif

// File: rtl/core/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;
  localparam int NumRounds = 10;
  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;
  localparam logic [0:0] KEY_HIGH_IDX = 1'b0;
  localparam logic [0:0] KEY_LOW_IDX  = 1'b1;

  typedef logic [127:0] blk_t;
  typedef logic [7:0] byte_t;

  function automatic byte_t xtime(input byte_t b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gmul(input byte_t a, input byte_t b);
    byte_t p;
    byte_t x;
    p = 8'h00;
    x = b;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic byte_t sbox(input byte_t x);
    byte_t sq;
    byte_t inv;
    sq = x;
    inv = 8'h01;
    for (int i = 0; i < 7; i++) begin
      sq = gmul(sq, sq);
      inv = gmul(inv, sq);
    end
    if (x == 8'h00) inv = 8'h00;
    sbox = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  typedef byte_t tab_t [256];

  function automatic tab_t make_sbox();
    tab_t t;
    for (int i = 0; i < 256; i++) t[i] = sbox(byte_t'(i));
    make_sbox = t;
  endfunction

  function automatic tab_t make_inv_sbox();
    tab_t t;
    for (int i = 0; i < 256; i++) t[sbox(byte_t'(i))] = byte_t'(i);
    make_inv_sbox = t;
  endfunction

  localparam tab_t SBOX = make_sbox();
  localparam tab_t INV_SBOX = make_inv_sbox();
endpackage
`default_nettype wire

// File: rtl/core/aes128_block_cipher.sv
// Pipeline: one initial key add, ten round stages, one output register; both directions
//   mixed, one block per cycle unless the output stalls or the key schedule is rebuilding.
// The key schedule is re-expanded after a key write, one round a cycle;
//   the input is held off until it completes.
// Reset (rst_n low, synchronous) clears valid bits and the key to zero; schedule rebuilds.
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_cipher (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [63:0] cfg_data,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [127:0] in_tdata,   // block_high, block_low
  input  wire  [0:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [127:0] out_tdata  // result_high, result_low
);
  import aes_pkg::*;

  localparam int NS = NumRounds + 1;

  // key schedule: rk_r[0] is the key, one round derived per cycle
  logic [127:0] key_r;
  logic [127:0] rk_r [NumRounds+1];
  logic [3:0]   kcnt_r;
  logic [7:0]   rcon_r;

  function automatic logic [127:0] next_rk(input logic [127:0] k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      kcnt_r <= 4'd0;
      rcon_r <= 8'h01;
      rk_r[0] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == KEY_HIGH_IDX) begin
        key_r[127:64] <= cfg_data;
        rk_r[0] <= {cfg_data, key_r[63:0]};
      end else begin
        key_r[63:0] <= cfg_data;
        rk_r[0] <= {key_r[127:64], cfg_data};
      end
      kcnt_r <= 4'd0;
      rcon_r <= 8'h01;
    end else if (kcnt_r != 4'(NumRounds)) begin
      // advance the schedule one round
      rk_r[kcnt_r + 4'd1] <= next_rk(rk_r[kcnt_r], rcon_r);
      kcnt_r <= kcnt_r + 4'd1;
      rcon_r <= xtime(rcon_r);
    end
  end

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    byte_t b [16];
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)%4)+r];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
        t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
        t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    enc_round = o;
  endfunction

  // inverse round: shift, sub, key add, then mix unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    byte_t b [16];
    byte_t t [16];
    byte_t a0, a1, a2, a3;
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = s[127-8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[4*c+r] = INV_SBOX[b[4*((c-r+4)%4)+r]] ^ k[127-8*(4*c+r) -: 8];
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      if (!last) begin
        t[4*c]   = gmul(8'h0e, a0) ^ gmul(8'h0b, a1) ^ gmul(8'h0d, a2) ^ gmul(8'h09, a3);
        t[4*c+1] = gmul(8'h09, a0) ^ gmul(8'h0e, a1) ^ gmul(8'h0b, a2) ^ gmul(8'h0d, a3);
        t[4*c+2] = gmul(8'h0d, a0) ^ gmul(8'h09, a1) ^ gmul(8'h0e, a2) ^ gmul(8'h0b, a3);
        t[4*c+3] = gmul(8'h0b, a0) ^ gmul(8'h0d, a1) ^ gmul(8'h09, a2) ^ gmul(8'h0e, a3);
      end
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
    dec_round = o;
  endfunction

  // pipeline: stage 0 initial key add, stages 1..10 rounds, then output register
  logic [127:0] st_r  [NS];
  logic         dec_r [NS];
  logic         vld_r [NS];
  logic         adv;
  logic         key_rdy;
  logic [127:0] blk_in;

  // whole pipe moves when the output slot is free or empty
  assign adv = !out_tvalid || out_tready;
  assign key_rdy = (kcnt_r == 4'(NumRounds));
  assign in_tready = adv && key_rdy;

  // block byte 0 sits at the top of the internal state
  assign blk_in = {in_tdata[63:0], in_tdata[127:64]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid && key_rdy;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
      out_tvalid <= vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r[0] <= in_tuser[0];
      st_r[0] <= blk_in ^ (in_tuser[0] == REQ_DECRYPT ? rk_r[NumRounds] : rk_r[0]);
      for (int i = 1; i < NS; i++) begin
        dec_r[i] <= dec_r[i-1];
        if (dec_r[i-1] == REQ_DECRYPT)
          st_r[i] <= dec_round(st_r[i-1], rk_r[NumRounds-i], i == NumRounds);
        else
          st_r[i] <= enc_round(st_r[i-1], i == NumRounds) ^ rk_r[i];
      end
      out_tdata <= {st_r[NS-1][63:0], st_r[NS-1][127:64]};
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/aes128_block_cipher_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_cipher_defines.svh"
module aes128_block_cipher_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [127:0] out_tdata
);
  // a stalled result holds its data
  `ASSERT_NEXT(out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // a waiting result blocks the input
  `ASSERT_NOW(stall_block, clk, rst_n, out_tvalid && !out_tready, !in_tready)
  // ready is driven whenever a beat is offered
  `ASSERT_NOW(ready_known, clk, rst_n, in_tvalid, !$isunknown(in_tready))
  // result valid is always driven
  `ASSERT_NOW(valid_known, clk, rst_n, 1'b1, !$isunknown(out_tvalid))
endmodule

bind aes128_block_cipher aes128_block_cipher_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

// File: test/aes128_block_cipher_test.sv
`timescale 1ns / 1ps
module aes128_block_cipher_test;
  import aes_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic        req;
    logic [63:0] blk_hi;
    logic [63:0] blk_lo;
  } block_req_t;

  typedef struct {
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } cipher_out_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // block_high, block_low
  logic [0:0]   in_tuser = '0;   // req_type
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // result_high, result_low

  aes128_block_cipher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: substitution tables, key and round-key words
  logic [7:0]  fwd_sub [256];
  logic [7:0]  inv_sub [256];
  logic [63:0] key_hi_q = '0;
  logic [63:0] key_lo_q = '0;
  logic [31:0] rk_words [44];

  block_req_t  pending_blocks [$];
  cipher_out_t expected_blocks [$];
  int          error_count = 0;
  bit          calm = 1'b0;
  int          stall_cycles = 0;

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (a[i]) p ^= b;
      b = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  task automatic build_sub_tables();
    logic [7:0] sq, inv, s;
    for (int x = 0; x < 256; x++) begin
      sq = x[7:0];
      inv = 8'h01;
      for (int i = 0; i < 7; i++) begin
        sq = gf_mult(sq, sq);
        inv = gf_mult(inv, sq);
      end
      if (x == 0) inv = 8'h00;
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sub[x] = s;
      inv_sub[s] = x[7:0];
    end
  endtask

  task automatic expand_round_keys();
    logic [31:0] t;
    logic [7:0]  rcon;
    rcon = 8'h01;
    rk_words[0] = key_hi_q[63:32];
    rk_words[1] = key_hi_q[31:0];
    rk_words[2] = key_lo_q[63:32];
    rk_words[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i += 4) begin
      t = {rk_words[i-1][23:0], rk_words[i-1][31:24]};
      t = {fwd_sub[t[31:24]], fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]]}
        ^ {rcon, 24'h0};
      rk_words[i]   = rk_words[i-4] ^ t;
      rk_words[i+1] = rk_words[i-3] ^ rk_words[i];
      rk_words[i+2] = rk_words[i-2] ^ rk_words[i+1];
      rk_words[i+3] = rk_words[i-1] ^ rk_words[i+2];
      rcon = gf_mult(rcon, 8'h02);
    end
  endtask

  // Byte n of the block is st[n]; column c, row r is st[4c+r]
  function automatic cipher_out_t aes_block(logic dec, logic [63:0] hi, logic [63:0] lo);
    logic [7:0]  st [16];
    logic [7:0]  tmp [16];
    logic [7:0]  col [4];
    logic [7:0]  coef [4];
    int          rnd, src;
    cipher_out_t res;
    for (int i = 0; i < 8; i++) begin
      st[i]   = hi[63-8*i -: 8];
      st[8+i] = lo[63-8*i -: 8];
    end
    if (dec) coef = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else coef = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int step = 0; step <= 10; step++) begin
      rnd = dec ? 10 - step : step;
      if (step > 0) begin
        // substitute and shift rows (order does not matter for bytewise ops)
        tmp = st;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = dec ? ((c - r + 4) & 3) : ((c + r) & 3);
            st[4*c+r] = dec ? inv_sub[tmp[4*src+r]] : fwd_sub[tmp[4*src+r]];
          end
        if (!dec && step < 10) st = mix_cols(st, coef);
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) st[4*c+r] ^= rk_words[4*rnd+c][31-8*r -: 8];
      if (dec && step > 0 && step < 10) st = mix_cols(st, coef);
    end
    for (int i = 0; i < 8; i++) begin
      res.res_hi[63-8*i -: 8] = st[i];
      res.res_lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  typedef logic [7:0] state_bytes_t [16];

  function automatic state_bytes_t mix_cols(state_bytes_t st, logic [7:0] coef [4]);
    state_bytes_t o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        o[4*c+r] = 8'h00;
        for (int j = 0; j < 4; j++) o[4*c+r] ^= gf_mult(coef[(4 + j - r) & 3], st[4*c+j]);
      end
    return o;
  endfunction

  // Driver: predict on each accepted beat, hold while stalled, else offer the next block or idle
  always @(posedge clk) begin
    block_req_t nxt;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        expected_blocks.push_back(aes_block(in_tuser[0], in_tdata[63:0], in_tdata[127:64]));
      if (!(in_tvalid && !in_tready)) begin
        if (pending_blocks.size() > 0 && (calm || $urandom_range(99) >= 30)) begin
          nxt = pending_blocks.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= nxt.req;
          in_tdata  <= {nxt.blk_lo, nxt.blk_hi};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each result beat with the oldest prediction
  always @(posedge clk) begin
    cipher_out_t exp_res;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result beat %h", out_tdata);
          error_count++;
        end else begin
          exp_res = expected_blocks.pop_front();
          if (out_tdata[63:0] !== exp_res.res_hi) begin
            $error("result_high expected %h actual %h", exp_res.res_hi, out_tdata[63:0]);
            error_count++;
          end
          if (out_tdata[127:64] !== exp_res.res_lo) begin
            $error("result_low expected %h actual %h", exp_res.res_lo, out_tdata[127:64]);
            error_count++;
          end
        end
      end
      out_tready <= calm || $urandom_range(99) >= 30;
    end
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("aes128_block_cipher verification failed");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic add_block(logic req, logic [63:0] hi, logic [63:0] lo);
    block_req_t b;
    b.req = req;
    b.blk_hi = hi;
    b.blk_lo = lo;
    pending_blocks.push_back(b);
  endtask

  task automatic wait_drained();
    wait (pending_blocks.size() == 0 && !in_tvalid && expected_blocks.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Load a new key while idle, then let the schedule rebuild
  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= KEY_HIGH_IDX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_index <= KEY_LOW_IDX;
    cfg_data <= lo;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_hi_q = hi;
    key_lo_q = lo;
    expand_round_keys();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_random_blocks(int count);
    logic [63:0] hi, lo;
    for (int i = 0; i < count; i++) begin
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      // occasionally pin a half to an extreme
      case ($urandom_range(15))
        0: hi = '0;
        1: lo = '1;
        default: ;
      endcase
      add_block($urandom_range(1) ? REQ_DECRYPT : REQ_ENCRYPT, hi, lo);
    end
  endtask

  initial begin
    build_sub_tables();
    expand_round_keys();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Reset key: extremes of the block in both directions
    add_block(REQ_ENCRYPT, '0, '0);
    add_block(REQ_DECRYPT, '0, '0);
    add_block(REQ_ENCRYPT, '1, '1);
    add_block(REQ_DECRYPT, '1, '1);
    add_block(REQ_ENCRYPT, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    add_block(REQ_DECRYPT, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    add_random_blocks(150);

    // Standard test key and vector, both directions
    load_key(64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f);
    add_block(REQ_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
    add_block(REQ_DECRYPT, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
    add_block(REQ_ENCRYPT, '1, '0);
    add_block(REQ_DECRYPT, '0, '1);
    add_random_blocks(200);

    // All-ones key
    load_key('1, '1);
    add_block(REQ_ENCRYPT, '0, '0);
    add_block(REQ_DECRYPT, '1, '1);
    add_random_blocks(200);

    // Full-rate stretch with no idling on either side
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    calm = 1'b1;
    add_random_blocks(300);
    wait_drained();
    calm = 1'b0;

    // Mixed keys, including the zero key written explicitly
    load_key('0, '0);
    add_random_blocks(200);
    for (int k = 0; k < 4; k++) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      add_random_blocks(200);
    end

    wait_drained();
    if (error_count == 0)
      $display("aes128_block_cipher verification clean");
    else
      $display("aes128_block_cipher verification failed");
    $finish;
  end
endmodule
